// ----- design/rroa_pkg.sv -----
`default_nettype none

package rroa_pkg;

    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RESULTS = 3;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // controller phases
    localparam logic [3:0] PH_WAIT    = 4'd0;
    localparam logic [3:0] PH_FWD     = 4'd1;
    localparam logic [3:0] PH_TURN    = 4'd2;
    localparam logic [3:0] PH_BACK    = 4'd3;
    localparam logic [3:0] PH_SCANL   = 4'd4;
    localparam logic [3:0] PH_SCANR   = 4'd5;
    localparam logic [3:0] PH_CENTER  = 4'd6;
    localparam logic [3:0] PH_AVOID   = 4'd7;
    localparam logic [3:0] PH_BLOCKED = 4'd8;

    // action codes
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_STOP     = 4'd1;
    localparam logic [3:0] ACT_FORWARD  = 4'd2;
    localparam logic [3:0] ACT_BACKWARD = 4'd3;
    localparam logic [3:0] ACT_TURN     = 4'd4;
    localparam logic [3:0] ACT_SWEEP    = 4'd5;
    localparam logic [3:0] ACT_LEFT     = 4'd6;
    localparam logic [3:0] ACT_RIGHT    = 4'd7;
    localparam logic [3:0] ACT_CENTER   = 4'd8;

    // front status codes
    localparam logic [1:0] FRONT_CLEAR    = 2'd0;
    localparam logic [1:0] FRONT_OBSTACLE = 2'd1;

    // configuration register indexes
    localparam logic [2:0] REG_FWD_CHANCE  = 3'd0;
    localparam logic [2:0] REG_WAIT_RANGE  = 3'd1;
    localparam logic [2:0] REG_FWD_RANGE   = 3'd2;
    localparam logic [2:0] REG_TURN_RANGE  = 3'd3;
    localparam logic [2:0] REG_AVOID_RANGE = 3'd4;
    localparam logic [2:0] REG_BACKUP      = 3'd5;
    localparam logic [2:0] REG_LOSS_TMO    = 3'd6;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic        motion_busy;
        logic        scan_complete;
        logic [1:0]  front_status;
        logic        reading_valid;
        logic [15:0] reading_mm;
        logic [6:0]  rand_percent;
        logic        rand_coin;
        logic [15:0] rand_fraction;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [16:0] amount;
    } emit_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [16:0] amount;
        logic [3:0]         state_now;
        logic               last;
    } out_item_t;

    // min + ((max - min) * fraction >> 16), min when the range is reversed
    function automatic logic [15:0] scale_range(input logic [31:0] range,
                                                input logic [15:0] frac);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] diff;
        logic [31:0] prod;
        lo   = range[15:0];
        hi   = range[31:16];
        diff = hi - lo;
        prod = diff * frac;
        if (hi <= lo)
            return lo;
        return lo + prod[31:16];
    endfunction

    function automatic logic signed [16:0] signed_amount(input logic [15:0] mag,
                                                         input logic neg);
        logic [16:0] ext;
        ext = {1'b0, mag};
        return neg ? $signed(17'd0 - ext) : $signed(ext);
    endfunction

endpackage

`default_nettype wire

// ----- design/random_roam_obstacle_avoider_core.sv -----
// path: an input is registered in the input stage, and its results are written to the result queue when it has room
// throughput: one input per cycle while results drain and the queue has room; each
//   result leaves in a cycle of its own, so an input with three results holds the
//   output until all three have left, and a 4-entry result queue sets how far intake runs ahead
// reset: phase blocked until a begin input, control and configuration registers at their defaults
`default_nettype none

module random_roam_obstacle_avoider_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                mode,
    input  wire  [31:0]        now_ms,
    input  wire                motion_busy,
    input  wire                scan_complete,
    input  wire  [1:0]         front_status,
    input  wire                reading_valid,
    input  wire  [15:0]        reading_mm,
    input  wire  [6:0]         rand_percent,
    input  wire                rand_coin,
    input  wire  [15:0]        rand_fraction,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [3:0]         action,
    output logic signed [16:0] amount,
    output logic [3:0]         state_now,
    output logic               last,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [2:0]         cfg_index,
    input  wire  [31:0]        cfg_data
);

    // configuration
    logic [6:0]  fwd_chance_reg;
    logic [31:0] wait_range_reg;
    logic [31:0] fwd_range_reg;
    logic [31:0] turn_range_reg;
    logic [31:0] avoid_range_reg;
    logic [15:0] backup_reg;
    logic [15:0] loss_tmo_reg;

    // controller state
    logic [3:0]  phase_reg,      phase_next;
    logic [31:0] wait_start_reg, wait_start_next;
    logic [15:0] wait_len_reg,   wait_len_next;
    logic        lost_reg,       lost_next;
    logic [31:0] lost_since_reg, lost_since_next;
    logic        left_ok_reg,    left_ok_next;
    logic        right_ok_reg,   right_ok_next;
    logic [15:0] left_dist_reg,  left_dist_next;
    logic [15:0] right_dist_reg, right_dist_next;
    logic        turn_left_reg,  turn_left_next;

    // input stage
    rroa_pkg::in_item_t s1_reg;
    logic               s1_valid_reg;
    logic               s1_fire;

    // result queue
    rroa_pkg::out_item_t              fifo_mem [rroa_pkg::FIFO_DEPTH];
    logic [rroa_pkg::PTR_W-1:0]       rd_ptr_reg, wr_ptr_reg;
    logic [rroa_pkg::CNT_W-1:0]       count_reg;
    logic                             pop;

    rroa_pkg::emit_t                  res [rroa_pkg::MAX_RESULTS];
    logic [rroa_pkg::NRES_W-1:0]      n_res;
    logic [31:0]                      range_sel;
    logic [15:0]                      scaled;
    logic                             pct_fwd;
    logic                             wait_done;
    logic                             loss_done;
    logic                             tl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_chance_reg  <= 7'd60;
            wait_range_reg  <= 32'd131072500;
            fwd_range_reg   <= 32'd65536200;
            turn_range_reg  <= 32'd11796510;
            avoid_range_reg <= 32'd9830460;
            backup_reg      <= 16'd150;
            loss_tmo_reg    <= 16'd500;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rroa_pkg::REG_FWD_CHANCE:  fwd_chance_reg  <= cfg_data[6:0];
                rroa_pkg::REG_WAIT_RANGE:  wait_range_reg  <= cfg_data;
                rroa_pkg::REG_FWD_RANGE:   fwd_range_reg   <= cfg_data;
                rroa_pkg::REG_TURN_RANGE:  turn_range_reg  <= cfg_data;
                rroa_pkg::REG_AVOID_RANGE: avoid_range_reg <= cfg_data;
                rroa_pkg::REG_BACKUP:      backup_reg      <= cfg_data[15:0];
                rroa_pkg::REG_LOSS_TMO:    loss_tmo_reg    <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    // an item leaves the input stage only when the queue can take three results
    assign s1_fire  = s1_valid_reg
                    && (count_reg <= rroa_pkg::CNT_W'(rroa_pkg::FIFO_DEPTH
                                                      - rroa_pkg::MAX_RESULTS));
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg.mode          <= mode;
            s1_reg.now_ms        <= now_ms;
            s1_reg.motion_busy   <= motion_busy;
            s1_reg.scan_complete <= scan_complete;
            s1_reg.front_status  <= front_status;
            s1_reg.reading_valid <= reading_valid;
            s1_reg.reading_mm    <= reading_mm;
            s1_reg.rand_percent  <= rand_percent;
            s1_reg.rand_coin     <= rand_coin;
            s1_reg.rand_fraction <= rand_fraction;
        end
    end

    // only one range gets scaled in any step, so a single multiplier serves all
    assign pct_fwd = s1_reg.rand_percent < fwd_chance_reg;

    always_comb
    begin
        range_sel = wait_range_reg;
        if (!s1_reg.mode)
        begin
            priority if (phase_reg == rroa_pkg::PH_WAIT)
                range_sel = pct_fwd ? fwd_range_reg : turn_range_reg;
            else if (phase_reg == rroa_pkg::PH_CENTER)
                range_sel = avoid_range_reg;
            else
                range_sel = wait_range_reg;
        end
    end

    assign scaled    = rroa_pkg::scale_range(range_sel, s1_reg.rand_fraction);
    assign wait_done = (s1_reg.now_ms - wait_start_reg) >= {16'd0, wait_len_reg};
    assign loss_done = (s1_reg.now_ms - lost_since_reg) >= {16'd0, loss_tmo_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        wait_start_next = wait_start_reg;
        wait_len_next   = wait_len_reg;
        lost_next       = lost_reg;
        lost_since_next = lost_since_reg;
        left_ok_next    = left_ok_reg;
        right_ok_next   = right_ok_reg;
        left_dist_next  = left_dist_reg;
        right_dist_next = right_dist_reg;
        turn_left_next  = turn_left_reg;
        n_res           = '0;
        tl              = 1'b0;
        for (int j = 0; j < rroa_pkg::MAX_RESULTS; j++)
            res[j] = '{action: rroa_pkg::ACT_NONE, amount: '0};

        if (s1_reg.mode)
        begin
            res[0]          = '{action: rroa_pkg::ACT_STOP, amount: '0};
            res[1]          = '{action: rroa_pkg::ACT_SWEEP, amount: '0};
            n_res           = 2'd2;
            phase_next      = rroa_pkg::PH_WAIT;
            wait_len_next   = scaled;
            wait_start_next = s1_reg.now_ms;
        end
        else
        begin
            unique case (phase_reg)
                rroa_pkg::PH_WAIT:
                begin
                    if (wait_done)
                    begin
                        if (pct_fwd)
                        begin
                            if (s1_reg.front_status == rroa_pkg::FRONT_CLEAR)
                            begin
                                phase_next = rroa_pkg::PH_FWD;
                                lost_next  = 1'b0;
                                res[0]     = '{action: rroa_pkg::ACT_FORWARD,
                                               amount: $signed({1'b0, scaled})};
                                n_res      = 2'd1;
                            end
                        end
                        else
                        begin
                            phase_next = rroa_pkg::PH_TURN;
                            res[0]     = '{action: rroa_pkg::ACT_CENTER, amount: '0};
                            res[1]     = '{action: rroa_pkg::ACT_TURN,
                                           amount: rroa_pkg::signed_amount(
                                               scaled, !s1_reg.rand_coin)};
                            n_res      = 2'd2;
                        end
                    end
                end
                rroa_pkg::PH_FWD:
                begin
                    if (s1_reg.front_status == rroa_pkg::FRONT_OBSTACLE)
                    begin
                        res[0]        = '{action: rroa_pkg::ACT_STOP, amount: '0};
                        res[1]        = '{action: rroa_pkg::ACT_CENTER, amount: '0};
                        res[2]        = '{action: rroa_pkg::ACT_BACKWARD,
                                          amount: $signed({1'b0, backup_reg})};
                        n_res         = 2'd3;
                        phase_next    = rroa_pkg::PH_BACK;
                        left_ok_next  = 1'b0;
                        right_ok_next = 1'b0;
                    end
                    else if (s1_reg.front_status != rroa_pkg::FRONT_CLEAR
                             && lost_reg && loss_done)
                    begin
                        // reading lost too long: stop and wait again
                        res[0]          = '{action: rroa_pkg::ACT_STOP, amount: '0};
                        res[1]          = '{action: rroa_pkg::ACT_SWEEP, amount: '0};
                        n_res           = 2'd2;
                        phase_next      = rroa_pkg::PH_WAIT;
                        wait_len_next   = scaled;
                        wait_start_next = s1_reg.now_ms;
                    end
                    else
                    begin
                        if (s1_reg.front_status == rroa_pkg::FRONT_CLEAR)
                            lost_next = 1'b0;
                        else if (!lost_reg)
                        begin
                            lost_next       = 1'b1;
                            lost_since_next = s1_reg.now_ms;
                        end
                        if (!s1_reg.motion_busy)
                        begin
                            res[0]          = '{action: rroa_pkg::ACT_SWEEP, amount: '0};
                            n_res           = 2'd1;
                            phase_next      = rroa_pkg::PH_WAIT;
                            wait_len_next   = scaled;
                            wait_start_next = s1_reg.now_ms;
                        end
                    end
                end
                rroa_pkg::PH_TURN, rroa_pkg::PH_AVOID:
                begin
                    if (!s1_reg.motion_busy)
                    begin
                        res[0]          = '{action: rroa_pkg::ACT_SWEEP, amount: '0};
                        n_res           = 2'd1;
                        phase_next      = rroa_pkg::PH_WAIT;
                        wait_len_next   = scaled;
                        wait_start_next = s1_reg.now_ms;
                    end
                end
                rroa_pkg::PH_BACK:
                begin
                    if (!s1_reg.motion_busy)
                    begin
                        phase_next = rroa_pkg::PH_SCANL;
                        res[0]     = '{action: rroa_pkg::ACT_LEFT, amount: '0};
                        n_res      = 2'd1;
                    end
                end
                rroa_pkg::PH_SCANL:
                begin
                    if (s1_reg.scan_complete)
                    begin
                        left_ok_next = s1_reg.reading_valid;
                        if (s1_reg.reading_valid)
                            left_dist_next = s1_reg.reading_mm;
                        phase_next = rroa_pkg::PH_SCANR;
                        res[0]     = '{action: rroa_pkg::ACT_RIGHT, amount: '0};
                        n_res      = 2'd1;
                    end
                end
                rroa_pkg::PH_SCANR:
                begin
                    if (s1_reg.scan_complete)
                    begin
                        right_ok_next = s1_reg.reading_valid;
                        if (s1_reg.reading_valid)
                            right_dist_next = s1_reg.reading_mm;
                        phase_next = rroa_pkg::PH_CENTER;
                        res[0]     = '{action: rroa_pkg::ACT_CENTER, amount: '0};
                        n_res      = 2'd1;
                    end
                end
                rroa_pkg::PH_CENTER:
                begin
                    if (s1_reg.scan_complete)
                    begin
                        if (!left_ok_reg && !right_ok_reg)
                        begin
                            res[0]     = '{action: rroa_pkg::ACT_STOP, amount: '0};
                            n_res      = 2'd1;
                            phase_next = rroa_pkg::PH_BLOCKED;
                        end
                        else
                        begin
                            // prefer the only valid side, else the longer one, else the coin
                            priority if (left_ok_reg && !right_ok_reg)
                                tl = 1'b1;
                            else if (!left_ok_reg && right_ok_reg)
                                tl = 1'b0;
                            else if (left_dist_reg != right_dist_reg)
                                tl = left_dist_reg > right_dist_reg;
                            else
                                tl = !s1_reg.rand_coin;
                            turn_left_next = tl;
                            phase_next     = rroa_pkg::PH_AVOID;
                            res[0]         = '{action: rroa_pkg::ACT_TURN,
                                               amount: rroa_pkg::signed_amount(scaled, tl)};
                            n_res          = 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rroa_pkg::PH_BLOCKED;
            wait_start_reg <= '0;
            wait_len_reg   <= '0;
            lost_reg       <= 1'b0;
            lost_since_reg <= '0;
            left_ok_reg    <= 1'b0;
            right_ok_reg   <= 1'b0;
            left_dist_reg  <= '0;
            right_dist_reg <= '0;
            turn_left_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg      <= phase_next;
            wait_start_reg <= wait_start_next;
            wait_len_reg   <= wait_len_next;
            lost_reg       <= lost_next;
            lost_since_reg <= lost_since_next;
            left_ok_reg    <= left_ok_next;
            right_ok_reg   <= right_ok_next;
            left_dist_reg  <= left_dist_next;
            right_dist_reg <= right_dist_next;
            turn_left_reg  <= turn_left_next;
        end
    end

    // result queue
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int j = 0; j < rroa_pkg::MAX_RESULTS; j++)
            begin
                if (rroa_pkg::NRES_W'(j) < n_res)
                    fifo_mem[wr_ptr_reg + rroa_pkg::PTR_W'(j)] <=
                        '{action:    res[j].action,
                          amount:    res[j].amount,
                          state_now: phase_next,
                          last:      (rroa_pkg::NRES_W'(j + 1) == n_res)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + rroa_pkg::PTR_W'(1);
            if (s1_fire)
                wr_ptr_reg <= wr_ptr_reg + rroa_pkg::PTR_W'(n_res);
            count_reg <= count_reg
                       + (s1_fire ? rroa_pkg::CNT_W'(n_res) : rroa_pkg::CNT_W'(0))
                       - (pop ? rroa_pkg::CNT_W'(1) : rroa_pkg::CNT_W'(0));
        end
    end

    assign out_valid = count_reg != '0;
    assign action    = fifo_mem[rd_ptr_reg].action;
    assign amount    = fifo_mem[rd_ptr_reg].amount;
    assign state_now = fifo_mem[rd_ptr_reg].state_now;
    assign last      = fifo_mem[rd_ptr_reg].last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rroa_pkg::CNT_W'(rroa_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= rroa_pkg::PH_BLOCKED)
        else $error("phase out of range");

    a_begin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_reg.mode) |=> phase_reg == rroa_pkg::PH_WAIT)
        else $error("begin did not enter waiting");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_reg.mode && phase_reg == rroa_pkg::PH_BLOCKED)
        |=> phase_reg == rroa_pkg::PH_BLOCKED)
        else $error("left blocked without begin");

    a_blocked_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_reg.mode && phase_reg == rroa_pkg::PH_BLOCKED)
        |=> count_reg <= $past(count_reg))
        else $error("blocked phase produced a result");
`endif

endmodule

`default_nettype wire
